// ----- rtl/lpp_pkg.sv -----
package lpp_pkg;

	localparam int ADC_BITS  = 12;
	localparam int FRAC_BITS = 8;
	localparam int NUM_LANES = 4;

	localparam int SUM_W    = ADC_BITS + 2;
	localparam int WSUM_W   = ADC_BITS + 3;
	localparam int SCALE    = 10;
	localparam int DIVD_W   = WSUM_W - 1 + 4 + FRAC_BITS;
	localparam int DCNT_W   = $clog2(DIVD_W + 1);
	localparam int ERR_W    = 16;
	localparam int GAIN_W   = 16;
	localparam int MARGIN_W = 12;
	localparam int LIMIT_W  = 13;
	localparam int CMP_W    = (ADC_BITS > MARGIN_W) ? ADC_BITS : MARGIN_W;
	localparam int MAC_W    = GAIN_W + ERR_W + 2;
	localparam int CORR_W   = 23;
	localparam int LERR_W   = 14;
	localparam int PADDR_W  = 5;
	localparam int RIDX_W   = 3;

	localparam logic signed [2:0] WEIGHT [NUM_LANES] = '{3'sd3, 3'sd1, -3'sd1, -3'sd3};

	localparam logic signed [ERR_W-1:0] ERR_BLACK = ERR_W'(25 << FRAC_BITS);

	localparam logic [GAIN_W-1:0]   GAIN_RST   = '0;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(400);
	localparam logic [LIMIT_W-1:0]  LIMIT_RST  =
		((30 << FRAC_BITS) > 8191) ? LIMIT_W'(8191) : LIMIT_W'(30 << FRAC_BITS);

	localparam logic [RIDX_W-1:0] REG_GAIN_P = 3'd0;
	localparam logic [RIDX_W-1:0] REG_GAIN_I = 3'd1;
	localparam logic [RIDX_W-1:0] REG_GAIN_D = 3'd2;
	localparam logic [RIDX_W-1:0] REG_MARGIN = 3'd3;
	localparam logic [RIDX_W-1:0] REG_LIMIT  = 3'd4;

	typedef struct packed {
		logic signed [WSUM_W-1:0] wterm;
		logic [ADC_BITS-1:0]      reading;
		logic                     above;
	} lane_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [LIMIT_W-1:0]       limit;
	} pid_cfg_t;

endpackage

// ----- rtl/line_position_pid_core.sv -----
// line position pid core
// input channel: in_valid/in_ready with four sensor readings per word; the four
// lanes weight and compare the readings, then a merge stage forms the weighted
// sum, the plain sum and the all-black flag.
// a restoring divider (one bit per cycle) turns the scaled weighted
// sum into the line error; one shared multiplier then runs the three pid terms.
// a new word is taken only once the previous one has passed the divider and the
// pid terms and has reached the output register.
// in_ready is high while the core is idle; a finished word waits in the output
// register, so the next input word may be taken while out_valid is still high
// and out_ready is low. a stalled receiver holds the result in place; the core
// finishes the next word and then waits until the output register frees up.
// apb port: gain_p 0x00, gain_i 0x04, gain_d 0x08, dark threshold 0x0c,
// integral_limit 0x10; write only while idle.
// reset clears gains, sets black margin 400 and integral limit 30.0,
// and clears the last error and the accumulated error.
module line_position_pid_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lpp_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lpp_pkg::ADC_BITS-1:0]       sensor_0,
	input  logic [lpp_pkg::ADC_BITS-1:0]       sensor_1,
	input  logic [lpp_pkg::ADC_BITS-1:0]       sensor_2,
	input  logic [lpp_pkg::ADC_BITS-1:0]       sensor_3,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lpp_pkg::CORR_W-1:0]  correction,
	output logic signed [lpp_pkg::LERR_W-1:0]  line_error,
	output logic                               all_black
);
	import lpp_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SUM  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_PID  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [GAIN_W-1:0]   gain_p_q;
	logic [GAIN_W-1:0]   gain_i_q;
	logic [GAIN_W-1:0]   gain_d_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic                wr_en;
	logic [RIDX_W-1:0]   ridx;

	logic [2:0]               state_q;
	logic [ADC_BITS-1:0]      sensors [NUM_LANES];
	lane_t                    lanes [NUM_LANES];
	logic signed [WSUM_W-1:0] wsum;
	logic [SUM_W-1:0]         sum;
	logic                     black;
	logic signed [WSUM_W-1:0] wsum_s1;
	logic [SUM_W-1:0]         sum_s1;
	logic                     black_s1;
	logic signed [WSUM_W-1:0] wneg;
	logic [WSUM_W-2:0]        wmag;
	logic [DIVD_W-1:0]        dividend;
	logic                     div_done;
	logic signed [ERR_W-1:0]  quot;
	logic signed [ERR_W-1:0]  err_q;
	logic                     pid_start_q;
	pid_cfg_t                 pid_cfg;
	logic                     pid_done;
	logic                     last_pos;
	logic signed [CORR_W-1:0] corr;
	logic                     accept;
	logic                     out_free;

	logic                     out_valid_q;
	logic signed [CORR_W-1:0] correction_q;
	logic signed [LERR_W-1:0] line_error_q;
	logic                     all_black_q;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign ridx   = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_RST;
			gain_i_q <= GAIN_RST;
			gain_d_q <= GAIN_RST;
			margin_q <= MARGIN_RST;
			limit_q  <= LIMIT_RST;
		end else if (wr_en) begin
			case (ridx)
				REG_GAIN_P: gain_p_q <= pwdata[GAIN_W-1:0];
				REG_GAIN_I: gain_i_q <= pwdata[GAIN_W-1:0];
				REG_GAIN_D: gain_d_q <= pwdata[GAIN_W-1:0];
				REG_MARGIN: margin_q <= pwdata[MARGIN_W-1:0];
				REG_LIMIT:  limit_q  <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_GAIN_P: prdata = 32'(gain_p_q);
			REG_GAIN_I: prdata = 32'(gain_i_q);
			REG_GAIN_D: prdata = 32'(gain_d_q);
			REG_MARGIN: prdata = 32'(margin_q);
			REG_LIMIT:  prdata = 32'(limit_q);
			default:    prdata = '0;
		endcase
	end

	// lanes
	assign sensors[0] = sensor_0;
	assign sensors[1] = sensor_1;
	assign sensors[2] = sensor_2;
	assign sensors[3] = sensor_3;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		lpp_lane u_lane (
			.sensor (sensors[g]),
			.weight (WEIGHT[g]),
			.margin (margin_q),
			.res    (lanes[g])
		);
	end

	// merge
	always_comb begin
		wsum  = '0;
		sum   = '0;
		black = 1'b1;
		for (int i = 0; i < NUM_LANES; i++) begin
			wsum  = wsum + lanes[i].wterm;
			sum   = sum + SUM_W'(lanes[i].reading);
			black = black & ~lanes[i].above;
		end
	end

	assign accept   = in_valid & in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = ~out_valid_q | out_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			wsum_s1  <= wsum;
			sum_s1   <= sum;
			black_s1 <= black;
		end
	end

	// |wsum| * 10 in q18.8
	assign wneg     = -wsum_s1;
	assign wmag     = wsum_s1[WSUM_W-1] ? wneg[WSUM_W-2:0] : wsum_s1[WSUM_W-2:0];
	assign dividend = (DIVD_W'(wmag) * DIVD_W'(SCALE)) << FRAC_BITS;

	lpp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SUM),
		.dividend (dividend),
		.divisor  (sum_s1),
		.neg      (wsum_s1[WSUM_W-1]),
		.done     (div_done),
		.quot     (quot)
	);

	assign pid_cfg.gain_p = gain_p_q;
	assign pid_cfg.gain_i = gain_i_q;
	assign pid_cfg.gain_d = gain_d_q;
	assign pid_cfg.limit  = limit_q;

	lpp_pid u_pid (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pid_start_q),
		.err      (err_q),
		.cfg      (pid_cfg),
		.done     (pid_done),
		.last_pos (last_pos),
		.corr     (corr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pid_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pid_start_q <= 1'b0;
			if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) state_q <= S_SUM;
				S_SUM:  state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						pid_start_q <= 1'b1;
						state_q     <= S_PID;
					end
				end
				S_PID: if (pid_done) state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_done) begin
			if (black_s1)
				err_q <= last_pos ? ERR_BLACK : -ERR_BLACK;
			else
				err_q <= quot;
		end
		if (state_q == S_OUT && out_free) begin
			correction_q <= corr;
			line_error_q <= LERR_W'(err_q);
			all_black_q  <= black_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign correction = correction_q;
	assign line_error = line_error_q;
	assign all_black  = all_black_q;

`ifndef SYNTHESIS
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide phase");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SUM)
		else $error("accepted word did not start the sum phase");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (line_error <= 14'sd7680 && line_error >= -14'sd7680))
		else $error("line error out of range");

	a_black_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && all_black) |->
			(line_error == LERR_W'(ERR_BLACK) || line_error == LERR_W'(-ERR_BLACK)))
		else $error("all-black word without the fixed error");

	a_pid_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		pid_start_q |-> $past(div_done))
		else $error("pid started without a quotient");
`endif

endmodule

// ----- rtl/lpp_lane.sv -----
module lpp_lane (
	input  logic [lpp_pkg::ADC_BITS-1:0] sensor,
	input  logic signed [2:0]            weight,
	input  logic [lpp_pkg::MARGIN_W-1:0] margin,
	output lpp_pkg::lane_t               res
);
	import lpp_pkg::*;

	logic signed [WSUM_W-1:0] sensor_ext;

	assign sensor_ext  = $signed({{(WSUM_W-ADC_BITS){1'b0}}, sensor});
	assign res.wterm   = sensor_ext * WSUM_W'(weight);
	assign res.reading = sensor;
	assign res.above   = CMP_W'(sensor) > CMP_W'(margin);

endmodule

// ----- rtl/lpp_div.sv -----
module lpp_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [lpp_pkg::DIVD_W-1:0]       dividend,
	input  logic [lpp_pkg::SUM_W-1:0]        divisor,
	input  logic                             neg,
	output logic                             done,
	output logic signed [lpp_pkg::ERR_W-1:0] quot
);
	import lpp_pkg::*;

	logic [DCNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  dsor_q;
	logic [DIVD_W-1:0] quo_q;
	logic              neg_q;
	logic              done_q;
	logic [SUM_W:0]    rem_sh;
	logic [SUM_W:0]    trial;
	logic              fits;
	logic [ERR_W-1:0]  mag;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
	assign trial  = rem_sh - {1'b0, dsor_q};
	assign fits   = rem_sh >= {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DCNT_W'(DIVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dsor_q <= divisor;
			quo_q  <= dividend;
			neg_q  <= neg;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial[SUM_W-1:0] : rem_sh[SUM_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign mag  = quo_q[ERR_W-1:0];
	assign quot = neg_q ? -$signed(mag) : $signed(mag);
	assign done = done_q;

endmodule

// ----- rtl/lpp_pid.sv -----
module lpp_pid (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [lpp_pkg::ERR_W-1:0]  err,
	input  lpp_pkg::pid_cfg_t                 cfg,
	output logic                              done,
	output logic                              last_pos,
	output logic signed [lpp_pkg::CORR_W-1:0] corr
);
	import lpp_pkg::*;

	localparam int SH_W = MAC_W - FRAC_BITS;
	localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((1 << (CORR_W - 1)) - 1);
	localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(1 << (CORR_W - 1));

	localparam logic [2:0] P_IDLE  = 3'd0;
	localparam logic [2:0] P_MAC_P = 3'd1;
	localparam logic [2:0] P_MAC_I = 3'd2;
	localparam logic [2:0] P_MAC_D = 3'd3;
	localparam logic [2:0] P_SAT   = 3'd4;

	logic [2:0]                    phase_q;
	logic signed [ERR_W-1:0]       last_q;
	logic signed [ERR_W-1:0]       iacc_q;
	logic signed [ERR_W-1:0]       err_q;
	logic signed [ERR_W-1:0]       diff_q;
	logic signed [MAC_W-1:0]       mac_q;
	logic signed [CORR_W-1:0]      corr_q;
	logic                          done_q;

	logic signed [ERR_W:0]         isum;
	logic signed [ERR_W:0]         lim;
	logic signed [ERR_W:0]         iclamp;
	logic signed [GAIN_W-1:0]      opa;
	logic signed [ERR_W-1:0]       opb;
	logic signed [GAIN_W+ERR_W-1:0] prod;
	logic signed [SH_W-1:0]        shifted;

	assign isum = (ERR_W+1)'(iacc_q) + (ERR_W+1)'(err);
	assign lim  = $signed({{(ERR_W+1-LIMIT_W){1'b0}}, cfg.limit});

	always_comb begin
		if (isum > lim)
			iclamp = lim;
		else if (isum < -lim)
			iclamp = -lim;
		else
			iclamp = isum;
	end

	// one shared multiplier walks the three terms
	always_comb begin
		case (phase_q)
			P_MAC_P: begin
				opa = cfg.gain_p;
				opb = err_q;
			end
			P_MAC_I: begin
				opa = cfg.gain_i;
				opb = iacc_q;
			end
			P_MAC_D: begin
				opa = cfg.gain_d;
				opb = diff_q;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod    = opa * opb;
	assign shifted = SH_W'(mac_q >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			last_q  <= '0;
			iacc_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				P_IDLE: begin
					if (start) begin
						last_q  <= err;
						iacc_q  <= ERR_W'(iclamp);
						phase_q <= P_MAC_P;
					end
				end
				P_MAC_P: phase_q <= P_MAC_I;
				P_MAC_I: phase_q <= P_MAC_D;
				P_MAC_D: phase_q <= P_SAT;
				P_SAT: begin
					done_q  <= 1'b1;
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == P_IDLE && start) begin
			err_q  <= err;
			diff_q <= ERR_W'(err - last_q);
			mac_q  <= '0;
		end else if (phase_q == P_MAC_P || phase_q == P_MAC_I || phase_q == P_MAC_D) begin
			mac_q <= mac_q + MAC_W'(prod);
		end else if (phase_q == P_SAT) begin
			if (shifted > SAT_HI)
				corr_q <= CORR_W'(SAT_HI);
			else if (shifted < SAT_LO)
				corr_q <= CORR_W'(SAT_LO);
			else
				corr_q <= CORR_W'(shifted);
		end
	end

	assign done     = done_q;
	assign corr     = corr_q;
	assign last_pos = last_q > 0;

endmodule
